// ===== design/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ole_pkg.sv =====
// types and codes shared by the ordered list engine
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REMOVE_AT  = 3'd5,
    OP_FIND       = 3'd6,
    OP_DUMP       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    op_t                       op;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic                      found;
    count_t                    count;
    logic signed [VALUE_W-1:0] element;
    logic                      last;
  } result_t;

  // what a cell does at the next edge
  typedef enum logic [1:0] {
    ACT_HOLD  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } cell_act_t;

endpackage

// ===== design/ole_cell.sv =====
// one storage cell of the shifting list, with its own equality compare
module ole_cell (
  input  logic                               clk,
  input  ole_pkg::cell_act_t                 act,
  input  logic signed [ole_pkg::VALUE_W-1:0] load_val,
  input  logic signed [ole_pkg::VALUE_W-1:0] left_val,
  input  logic signed [ole_pkg::VALUE_W-1:0] right_val,
  input  logic signed [ole_pkg::VALUE_W-1:0] key,
  output logic signed [ole_pkg::VALUE_W-1:0] val,
  output logic                               match
);

  always_ff @(posedge clk) begin
    unique case (act)
      ole_pkg::ACT_HOLD:  val <= val;
      ole_pkg::ACT_LOAD:  val <= load_val;
      ole_pkg::ACT_LEFT:  val <= left_val;
      ole_pkg::ACT_RIGHT: val <= right_val;
    endcase
  end

  assign match = (val == key);

endmodule

// ===== design/ordered_list_engine.sv =====
// top level of the ordered list engine: control, count and the row of cells
// every operation but dump: result registered at acceptance and strobed in the cycle after,
//   so a new transaction can start every cycle while the engine is not busy
// dump of n elements: busy until the last of its n results, which come on consecutive cycles;
//   the row rotates once through cell 0 and ends as it began
// synchronous reset empties the list (count zero); cell contents are not cleared
module ordered_list_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ole_pkg::cmd_t    cmd,
  output logic             done,
  output ole_pkg::result_t result
);

  localparam int CAPACITY = ole_pkg::CAPACITY;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       dump_left;
  logic [CW-1:0]       count_next;

  logic                accept;
  logic [CMPW-1:0]     cnt_ext;
  logic [CMPW-1:0]     cnt_m1;
  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     sel_pos;
  logic                ins_en;
  logic                rem_en;
  logic                full;
  logic                empty;
  logic                found;
  ole_pkg::status_t    status;

  logic signed [ole_pkg::VALUE_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]                cell_match;
  logic [CAPACITY-1:0]                hit;
  ole_pkg::cell_act_t                 cell_act [CAPACITY];
  logic signed [ole_pkg::VALUE_W-1:0] load_val;

  assign busy    = (state == S_DUMP);
  assign accept  = start && !busy;
  assign cnt_ext = CMPW'(count);
  assign cnt_m1  = cnt_ext - CMPW'(1);
  assign pos_ext = CMPW'(cmd.position);
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign found   = |hit;

  // during a dump the head value wraps around to the tail
  assign load_val = busy ? cell_val[0] : cmd.value;

  always_comb begin
    ins_en     = 1'b0;
    rem_en     = 1'b0;
    sel_pos    = '0;
    status     = ole_pkg::ST_OK;
    count_next = count;
    unique case (cmd.op)
      ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK, ole_pkg::OP_INSERT_AT: begin
        sel_pos = (cmd.op == ole_pkg::OP_PUSH_FRONT) ? '0 :
                  (cmd.op == ole_pkg::OP_PUSH_BACK)  ? cnt_ext : pos_ext;
        if (full) begin
          status = ole_pkg::ST_FULL;
        end else if (cmd.op == ole_pkg::OP_INSERT_AT && pos_ext >= cnt_ext) begin
          status = ole_pkg::ST_RANGE;
        end else begin
          ins_en     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      ole_pkg::OP_POP_FRONT, ole_pkg::OP_POP_BACK, ole_pkg::OP_REMOVE_AT: begin
        sel_pos = (cmd.op == ole_pkg::OP_POP_FRONT) ? '0 :
                  (cmd.op == ole_pkg::OP_POP_BACK)  ? cnt_m1 : pos_ext;
        if (empty) begin
          status = ole_pkg::ST_EMPTY;
        end else if (cmd.op == ole_pkg::OP_REMOVE_AT && pos_ext >= cnt_ext) begin
          status = ole_pkg::ST_RANGE;
        end else begin
          rem_en     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      ole_pkg::OP_FIND: begin
        status = ole_pkg::ST_OK;
      end
      ole_pkg::OP_DUMP: begin
        status = empty ? ole_pkg::ST_EMPTY : ole_pkg::ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMPW-1:0] IDX = CMPW'(i);
    logic signed [ole_pkg::VALUE_W-1:0] left_val;
    logic signed [ole_pkg::VALUE_W-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    assign hit[i] = cell_match[i] && (IDX < cnt_ext);

    always_comb begin
      cell_act[i] = ole_pkg::ACT_HOLD;
      priority if (busy) begin
        // rotate toward the front, head goes to the tail
        if (IDX < cnt_m1) begin
          cell_act[i] = ole_pkg::ACT_RIGHT;
        end else if (IDX == cnt_m1) begin
          cell_act[i] = ole_pkg::ACT_LOAD;
        end
      end else if (accept && ins_en) begin
        if (IDX == sel_pos) begin
          cell_act[i] = ole_pkg::ACT_LOAD;
        end else if (IDX > sel_pos && IDX <= cnt_ext) begin
          cell_act[i] = ole_pkg::ACT_LEFT;
        end
      end else if (accept && rem_en) begin
        if (IDX >= sel_pos && IDX < cnt_m1) begin
          cell_act[i] = ole_pkg::ACT_RIGHT;
        end
      end
    end

    ole_cell u_cell (
      .clk       (clk),
      .act       (cell_act[i]),
      .load_val  (load_val),
      .left_val  (left_val),
      .right_val (right_val),
      .key       (cmd.value),
      .val       (cell_val[i]),
      .match     (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_left <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (cmd.op == ole_pkg::OP_DUMP && !empty) begin
              state     <= S_DUMP;
              dump_left <= count;
            end else begin
              done           <= 1'b1;
              result.status  <= status;
              result.found   <= (cmd.op == ole_pkg::OP_FIND) && found;
              result.count   <= ole_pkg::count_t'(count_next);
              result.element <= '0;
              result.last    <= 1'b1;
            end
          end
        end
        S_DUMP: begin
          done           <= 1'b1;
          result.status  <= ole_pkg::ST_OK;
          result.found   <= 1'b0;
          result.count   <= ole_pkg::count_t'(count);
          result.element <= cell_val[0];
          result.last    <= (dump_left == CW'(1));
          dump_left      <= dump_left - CW'(1);
          if (dump_left == CW'(1)) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== design/ole_checker.sv =====
// port-level checker for the ordered list engine and its bind
`include "assert_macros.svh"

module ole_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input ole_pkg::cmd_t    cmd,
  input logic             done,
  input ole_pkg::result_t result
);

  // a dump streams its elements on consecutive cycles
  `ASSERT_CLK(a_dump_stream, clk, rst, done && !result.last |=> done, "dump stream broke off")

  // the engine stays busy until the final element of a dump is out
  `ASSERT_CLK(a_busy_in_dump, clk, rst, done && !result.last |-> busy, "not busy mid-dump")

  // every accepted transaction other than dump answers in the next cycle
  `ASSERT_CLK(a_single_latency, clk, rst,
    start && !busy && cmd.op != ole_pkg::OP_DUMP |=> done && result.last,
    "missing single result")

  // a find hit is a single ok result
  `ASSERT_CLK(a_found_ok, clk, rst,
    done && result.found |-> result.status == ole_pkg::ST_OK && result.last,
    "found flag on a bad result")

  // an empty answer means nothing is stored
  `ASSERT_CLK(a_empty_count, clk, rst,
    done && result.status == ole_pkg::ST_EMPTY |-> result.count == '0,
    "empty status with nonzero count")

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);

// ===== tb/ordered_list_engine_tb.sv =====
// self-checking testbench for the ordered list engine: directed table, then random traffic
`timescale 1ns / 1ps

module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int DEPTH = CAPACITY;
  localparam int RANDOM_ITEMS = 375;
  localparam int STALL_LIMIT = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    op_t                       op;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
    logic                      typed;
    status_t                   status;
    logic                      found;
    count_t                    count;
  } step_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  // shadow copy of the list
  logic signed [VALUE_W-1:0] list_mem [DEPTH];
  int                        list_len;
  result_t                   awaited_results [$];

  int mismatches;
  int idle_cycles;
  int calm_left;

  // typed rows carry the expected status, found and count
  step_row_t directed_steps [0:20] = '{
    '{OP_DUMP,       4'd0,  32'sd0,           1'b1, ST_EMPTY, 1'b0, 5'd0},
    '{OP_POP_FRONT,  4'd0,  32'sd0,           1'b1, ST_EMPTY, 1'b0, 5'd0},
    '{OP_POP_BACK,   4'd15, -32'sd1,          1'b1, ST_EMPTY, 1'b0, 5'd0},
    '{OP_REMOVE_AT,  4'd0,  32'sd0,           1'b1, ST_EMPTY, 1'b0, 5'd0},
    '{OP_INSERT_AT,  4'd0,  32'sd7,           1'b1, ST_RANGE, 1'b0, 5'd0},
    '{OP_FIND,       4'd0,  32'sd0,           1'b1, ST_OK,    1'b0, 5'd0},
    '{OP_PUSH_BACK,  4'd0,  32'sh7fffffff,    1'b1, ST_OK,    1'b0, 5'd1},
    '{OP_POP_FRONT,  4'd0,  32'sd0,           1'b1, ST_OK,    1'b0, 5'd0},
    '{OP_PUSH_FRONT, 4'd15, 32'sh80000000,    1'b1, ST_OK,    1'b0, 5'd1},
    '{OP_REMOVE_AT,  4'd0,  32'sd0,           1'b1, ST_OK,    1'b0, 5'd0},
    '{OP_PUSH_BACK,  4'd0,  -32'sd1,          1'b1, ST_OK,    1'b0, 5'd1},
    '{OP_PUSH_FRONT, 4'd0,  32'sd0,           1'b1, ST_OK,    1'b0, 5'd2},
    '{OP_INSERT_AT,  4'd0,  32'sd5,           1'b1, ST_OK,    1'b0, 5'd3},
    '{OP_INSERT_AT,  4'd2,  32'sh7fffffff,    1'b1, ST_OK,    1'b0, 5'd4},
    '{OP_INSERT_AT,  4'd4,  32'sd9,           1'b1, ST_RANGE, 1'b0, 5'd4},
    '{OP_REMOVE_AT,  4'd15, 32'sd0,           1'b1, ST_RANGE, 1'b0, 5'd4},
    '{OP_FIND,       4'd0,  -32'sd1,          1'b0, ST_OK,    1'b0, 5'd0},
    '{OP_FIND,       4'd0,  32'sh80000000,    1'b0, ST_OK,    1'b0, 5'd0},
    '{OP_DUMP,       4'd0,  32'sd0,           1'b0, ST_OK,    1'b0, 5'd0},
    '{OP_POP_BACK,   4'd0,  32'sd0,           1'b0, ST_OK,    1'b0, 5'd0},
    '{OP_REMOVE_AT,  4'd1,  32'sd0,           1'b0, ST_OK,    1'b0, 5'd0}
  };

  logic signed [VALUE_W-1:0] value_pool [8] = '{
    32'sh80000000, 32'sh7fffffff, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd100
  };

  ordered_list_engine uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic list_insert(input int p, input logic signed [VALUE_W-1:0] v);
    for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
    list_mem[p] = v;
    list_len++;
  endtask

  task automatic list_remove(input int p);
    for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endtask

  // updates the shadow list and queues the results one command gives
  task automatic apply_list_op(input cmd_t c, input bit use_typed, input result_t typed_res);
    result_t r;
    status_t st;
    logic    hit;
    st  = ST_OK;
    hit = 1'b0;
    case (c.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else list_insert((c.op == OP_PUSH_FRONT) ? 0 : list_len, c.value);
      end
      OP_INSERT_AT: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else if (int'(c.position) >= list_len) st = ST_RANGE;
        else list_insert(int'(c.position), c.value);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_remove((c.op == OP_POP_FRONT) ? 0 : list_len - 1);
      end
      OP_REMOVE_AT: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (int'(c.position) >= list_len) st = ST_RANGE;
        else list_remove(int'(c.position));
      end
      OP_FIND: begin
        for (int i = 0; i < list_len; i++) if (list_mem[i] == c.value) hit = 1'b1;
      end
      default: begin
        if (list_len == 0) st = ST_EMPTY;
      end
    endcase
    r.status  = st;
    r.found   = hit;
    r.count   = count_t'(list_len);
    r.element = '0;
    r.last    = 1'b1;
    if (use_typed) begin
      awaited_results.push_back(typed_res);
    end else if (c.op == OP_DUMP && list_len > 0) begin
      for (int i = 0; i < list_len; i++) begin
        r.element = list_mem[i];
        r.last    = (i == list_len - 1);
        awaited_results.push_back(r);
      end
    end else begin
      awaited_results.push_back(r);
    end
  endtask

  // idle gap before a transaction, with runs of back-to-back traffic
  function automatic int pick_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(5, 20);
    return $urandom_range(0, 8);
  endfunction

  // returns at the edge where the transaction is taken
  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_step(input cmd_t c, input bit use_typed, input result_t typed_res);
    send_cmd(c);
    apply_list_op(c, use_typed, typed_res);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with nothing expected: status=%0d count=%0d element=%0d",
                   $realtime, result.status, result.count, result.element);
        mismatches++;
      end else begin
        result_t want;
        want = awaited_results.pop_front();
        if (result.status !== want.status || result.found !== want.found ||
            result.count !== want.count || result.element !== want.element ||
            result.last !== want.last) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch exp st=%0d fnd=%0d cnt=%0d el=%0d last=%0d,",
                     $realtime, want.status, want.found, want.count, want.element,
                     want.last, " got st=%0d fnd=%0d cnt=%0d el=%0d last=%0d",
                     result.status, result.found, result.count,
                     result.element, result.last);
          mismatches++;
        end
      end
    end
  end

  // ends a hung run
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_t    c;
    result_t tr;
    int      r;
    bit      grow;
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    calm_left   = 0;
    list_len    = 0;
    grow        = 1'b1;
    foreach (list_mem[i]) list_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      c.op       = directed_steps[i].op;
      c.position = directed_steps[i].position;
      c.value    = directed_steps[i].value;
      tr.status  = directed_steps[i].status;
      tr.found   = directed_steps[i].found;
      tr.count   = directed_steps[i].count;
      tr.element = '0;
      tr.last    = 1'b1;
      run_step(c, directed_steps[i].typed, tr);
    end

    // fill to capacity, then probe the full list
    while (list_len < DEPTH) begin
      c.op       = list_len[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
      c.position = POS_W'($urandom_range(0, 15));
      c.value    = $urandom;
      run_step(c, 1'b0, '0);
    end
    run_step('{OP_PUSH_FRONT, 4'd0, 32'sd1}, 1'b0, '0);
    run_step('{OP_PUSH_BACK, 4'd0, 32'sd2}, 1'b0, '0);
    run_step('{OP_INSERT_AT, 4'd15, 32'sd3}, 1'b0, '0);
    run_step('{OP_DUMP, 4'd0, 32'sd0}, 1'b0, '0);
    run_step('{OP_FIND, 4'd0, list_mem[DEPTH-1]}, 1'b0, '0);
    run_step('{OP_REMOVE_AT, 4'd15, 32'sd0}, 1'b0, '0);
    run_step('{OP_INSERT_AT, 4'd15, 32'sd4}, 1'b0, '0);
    run_step('{OP_INSERT_AT, 4'd14, 32'sh80000000}, 1'b0, '0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) begin
        // let the pipeline drain completely once
        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() > 0) @(posedge clk);
      end
      if (list_len >= DEPTH) grow = 1'b0;
      else if (list_len == 0) grow = 1'b1;
      r          = $urandom_range(0, 99);
      c.position = POS_W'((list_len > 0 && $urandom_range(0, 4) != 0) ?
                          $urandom_range(0, list_len - 1) : $urandom_range(0, 15));
      c.value    = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
      if (r < 10) begin
        c.op = op_t'($urandom_range(0, 7));
      end else if (r < 18) begin
        c.op = OP_DUMP;
      end else if (r < 30) begin
        c.op = OP_FIND;
        if (list_len > 0 && $urandom_range(0, 1))
          c.value = list_mem[$urandom_range(0, list_len - 1)];
      end else if (r < (grow ? 78 : 52)) begin
        c.op = op_t'($urandom_range(OP_PUSH_FRONT, OP_INSERT_AT));
      end else begin
        c.op = op_t'($urandom_range(OP_POP_FRONT, OP_REMOVE_AT));
      end
      run_step(c, 1'b0, '0);
    end

    start <= 1'b0;
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
